FILE: hdl/ocpa_pkg.sv
// shared types, constants and helper functions of the correlation engine
`default_nettype none

package ocpa_pkg;

    // transaction kinds
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_TRACES = 2'd1;
    localparam logic [1:0] STATUS_ZERO_VAR  = 2'd2;

    localparam int IDX_FIELD_W = 12;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 13;
    localparam int CORR_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int TRK_W       = 17;
    localparam int SQ_W        = 160;

    // one point entry of the statistics memory
    typedef struct packed {
        logic [31:0] mean;
        logic [63:0] m2;
        logic [63:0] cov;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // magnitude of a 33-bit signed value known to stay below 2^32
    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] n;
        n = 33'd0 - v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    // mean plus signed step, result known to fit 32 bits
    function automatic logic [31:0] mean_step(input logic [31:0] m, input logic [32:0] q);
        logic [32:0] s;
        s = {m[31], m} + q;
        return s[31:0];
    endfunction

    // 64-bit accumulate with saturation at the signed limits
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [48:0] b);
        logic [64:0] s;
        s = {a[63], a} + {{16{b[48]}}, b};
        if (s[64:63] == 2'b01) begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else if (s[64:63] == 2'b10) begin
            return 64'h8000_0000_0000_0000;
        end
        return s[63:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/online_correlation_power_analysis.sv
// online welford statistics and pearson correlation engine, top level
// update: the first sample of a trace adds a second divide, for the hypothesis statistics
// read: two 64x64 products over a shared 32x32 multiplier, then a 16-step root
// per-point divides by the trace count run one quotient bit a cycle
// one transaction in work at a time; a finished read result waits in the output register
// reset: asynchronous, active low; then a clearing pass over all MAX_POINTS entries zeroes the memory
`default_nettype none

module online_correlation_power_analysis
    import ocpa_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // update / read transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // point_index, sample, hypothesis, zero pad
    input  wire logic [1:0]  s_axis_tuser,  // operation, first_of_trace
    // correlation results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // correlation
    output logic [1:0]       m_axis_tuser,  // status
    // points_in_use register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [TRK_W-1:0] MAXP = TRK_W'(MAX_POINTS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_POINTS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_HYP_DEV, ST_DIV, ST_HYP_MEAN, ST_HYP_MUL, ST_HYP_ACC,
        ST_PT_CHECK, ST_PT_LOAD, ST_PT_DEV, ST_PT_MEAN, ST_PT_MUL1, ST_PT_MUL2, ST_PT_WRITE,
        ST_RD_CHECK, ST_RD_LOAD, ST_WMUL, ST_WACC, ST_SQ_ADD, ST_SQ_CMP, ST_RD_FIN, ST_OUT
    } state_t;

    // control and architectural state
    state_t                  state_reg;
    logic [IDX_W-1:0]        clr_addr_reg;
    logic [CFG_W-1:0]        pu_reg;
    logic [31:0]             count_reg;
    logic [31:0]             hmean_reg;
    logic [63:0]             hm2_reg;
    logic                    div_pt_reg;
    logic [CORR_W-1:0]       res_corr_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic                    m_tvalid_reg;
    logic [CORR_W-1:0]       m_corr_reg;
    logic [STATUS_W-1:0]     m_status_reg;

    // captured transaction
    logic [IDX_FIELD_W-1:0]  idx_reg;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic [SAMPLE_W-1:0]     hyp_reg;

    // datapath scratch
    logic [31:0]             pmean_reg;
    logic [63:0]             pm2_reg;
    logic [63:0]             pcov_reg;
    logic [32:0]             dev_reg;
    logic [31:0]             div_rem_reg;
    logic [31:0]             div_quo_reg;
    logic [4:0]              div_cnt_reg;
    logic [63:0]             mul_p_reg;
    logic                    mul_neg_reg;
    logic [63:0]             wa_reg;
    logic [63:0]             wb_reg;
    logic [127:0]            acc_reg;
    logic [1:0]              wcnt_reg;
    logic                    wsel_reg;
    logic [127:0]            den_reg;
    logic [SQ_W-1:0]         num_reg;
    logic [SQ_W-1:0]         sq_s_reg;
    logic [SQ_W-1:0]         sq_a_reg;
    logic [SQ_W-1:0]         sq_b_reg;
    logic [SQ_W-1:0]         cand_reg;
    logic [3:0]              k_reg;
    logic [15:0]             q_reg;
    logic                    cov_neg_reg;
    logic [63:0]             cov_mag_reg;

    // ram
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    entry_t                  rd_entry;
    entry_t                  wr_entry;

    // combinational datapath
    logic [31:0]             yq;
    logic [31:0]             xq;
    logic [IDX_W+IDX_FIELD_W-1:0] idx_ext;
    logic [IDX_W-1:0]        idx_addr;
    logic [TRK_W-1:0]        pu_ext;
    logic [TRK_W-1:0]        tracked;
    logic                    in_range;
    logic [31:0]             dev_mag;
    logic [32:0]             quo_mag33;
    logic [32:0]             div_q;
    logic [32:0]             rem_sh;
    logic                    rem_ge;
    logic [32:0]             hyp_e;
    logic [32:0]             pt_e;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic                    mul_neg;
    logic [48:0]             pmag;
    logic [48:0]             sprod;
    logic [127:0]            part_sh;
    logic [127:0]            acc_sum;
    logic                    rd_ok;
    logic [15:0]             lo16;
    logic [15:0]             neg_lo16;

    assign yq = {hyp_reg, 16'h0000};
    assign xq = {sample_reg, 16'h0000};

    // the index field is widened or cut to the memory address width
    assign idx_ext  = {{IDX_W{1'b0}}, idx_reg};
    assign idx_addr = idx_ext[IDX_W-1:0];

    // tracked points, register clamped to 1 .. MAX_POINTS
    assign pu_ext   = {{(TRK_W-CFG_W){1'b0}}, pu_reg};
    assign tracked  = (pu_reg == '0) ? TRK_W'(1) : ((pu_ext > MAXP) ? MAXP : pu_ext);
    assign in_range = {{(TRK_W-IDX_FIELD_W){1'b0}}, idx_reg} < tracked;

    // divider: magnitude quotient, sign follows the deviation (truncation toward zero)
    assign dev_mag   = mag33(dev_reg);
    assign quo_mag33 = {1'b0, div_quo_reg};
    assign div_q     = dev_reg[32] ? (33'd0 - quo_mag33) : quo_mag33;
    assign rem_sh    = {div_rem_reg, div_quo_reg[31]};
    assign rem_ge    = rem_sh >= {1'b0, count_reg};

    assign hyp_e = {yq[31], yq} - {hmean_reg[31], hmean_reg};
    assign pt_e  = {xq[31], xq} - {pmean_reg[31], pmean_reg};

    // shared 32x32 multiplier operand selection
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (state_reg)
            ST_HYP_MUL, ST_PT_MUL2:
            begin
                mul_a   = dev_mag;
                mul_b   = mag33(hyp_e);
                mul_neg = dev_reg[32] ^ hyp_e[32];
            end
            ST_PT_MUL1:
            begin
                mul_a   = dev_mag;
                mul_b   = mag33(pt_e);
                mul_neg = dev_reg[32] ^ pt_e[32];
            end
            ST_WMUL:
            begin
                mul_a = wcnt_reg[0] ? wa_reg[63:32] : wa_reg[31:0];
                mul_b = wcnt_reg[1] ? wb_reg[63:32] : wb_reg[31:0];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // product scaled by 2^-16 with truncated magnitude
    assign pmag  = {1'b0, mul_p_reg[63:16]};
    assign sprod = mul_neg_reg ? (49'd0 - pmag) : pmag;

    // partial product placed by its limb weight
    always_comb
    begin
        unique case (wcnt_reg)
            2'd0:    part_sh = {64'd0, mul_p_reg};
            2'd1:    part_sh = {32'd0, mul_p_reg, 32'd0};
            2'd2:    part_sh = {32'd0, mul_p_reg, 32'd0};
            default: part_sh = {mul_p_reg, 64'd0};
        endcase
    end
    assign acc_sum = acc_reg + part_sh;

    assign rd_entry = entry_t'(ram_rdata);
    assign rd_ok    = ($signed(rd_entry.m2) > 64'sd0) && ($signed(hm2_reg) > 64'sd0);

    // root result capped at 32768 before the sign is applied
    assign lo16     = (q_reg > 16'd32768) ? 16'd32768 : q_reg;
    assign neg_lo16 = 16'd0 - lo16;

    // memory write: clearing pass or point write-back
    assign wr_entry.mean = pmean_reg;
    assign wr_entry.m2   = pm2_reg;
    assign wr_entry.cov  = sat_add(pcov_reg, sprod);
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_PT_WRITE);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : ENTRY_W'(wr_entry);

    ocpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_addr),
        .rdata (ram_rdata)
    );

    // sequencer, architectural state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            pu_reg         <= CFG_W'(4096);
            count_reg      <= '0;
            hmean_reg      <= '0;
            hm2_reg        <= '0;
            div_pt_reg     <= 1'b0;
            res_corr_reg   <= '0;
            res_status_reg <= STATUS_OK;
            m_tvalid_reg   <= 1'b0;
            m_corr_reg     <= '0;
            m_status_reg   <= STATUS_OK;
        end
        else
        begin
            if (cfg_valid)
            begin
                pu_reg <= cfg_data;
            end
            // a result leaving while a new one is loaded is handled in the output state
            if (m_tvalid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser[0] == OP_READ)
                        begin
                            state_reg <= ST_RD_CHECK;
                        end
                        else if (s_axis_tuser[1])
                        begin
                            state_reg <= ST_HYP_DEV;
                        end
                        else
                        begin
                            state_reg <= ST_PT_CHECK;
                        end
                    end
                end
                // first sample of a trace: count, then hypothesis statistics
                ST_HYP_DEV:
                begin
                    if (count_reg != 32'hFFFF_FFFF)
                    begin
                        count_reg <= count_reg + 32'd1;
                    end
                    div_pt_reg <= 1'b0;
                    state_reg  <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == 5'd31)
                    begin
                        state_reg <= div_pt_reg ? ST_PT_MEAN : ST_HYP_MEAN;
                    end
                end
                ST_HYP_MEAN:
                begin
                    hmean_reg <= mean_step(hmean_reg, div_q);
                    state_reg <= ST_HYP_MUL;
                end
                ST_HYP_MUL:
                begin
                    state_reg <= ST_HYP_ACC;
                end
                ST_HYP_ACC:
                begin
                    hm2_reg   <= sat_add(hm2_reg, sprod);
                    state_reg <= ST_PT_CHECK;
                end
                // point statistics: read, modify, write back
                ST_PT_CHECK:
                begin
                    state_reg <= (count_reg == '0 || !in_range) ? ST_IDLE : ST_PT_LOAD;
                end
                ST_PT_LOAD:
                begin
                    state_reg <= ST_PT_DEV;
                end
                ST_PT_DEV:
                begin
                    div_pt_reg <= 1'b1;
                    state_reg  <= ST_DIV;
                end
                ST_PT_MEAN:
                begin
                    state_reg <= ST_PT_MUL1;
                end
                ST_PT_MUL1:
                begin
                    state_reg <= ST_PT_MUL2;
                end
                ST_PT_MUL2:
                begin
                    state_reg <= ST_PT_WRITE;
                end
                ST_PT_WRITE:
                begin
                    state_reg <= ST_IDLE;
                end
                // correlation read
                ST_RD_CHECK:
                begin
                    res_corr_reg <= '0;
                    if (!in_range)
                    begin
                        res_status_reg <= STATUS_ZERO_VAR;
                        state_reg      <= ST_OUT;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_reg <= STATUS_NO_TRACES;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_RD_LOAD;
                    end
                end
                ST_RD_LOAD:
                begin
                    if (rd_ok)
                    begin
                        state_reg <= ST_WMUL;
                    end
                    else
                    begin
                        res_status_reg <= STATUS_ZERO_VAR;
                        state_reg      <= ST_OUT;
                    end
                end
                ST_WMUL:
                begin
                    state_reg <= ST_WACC;
                end
                ST_WACC:
                begin
                    state_reg <= (wcnt_reg == 2'd3 && wsel_reg) ? ST_SQ_ADD : ST_WMUL;
                end
                ST_SQ_ADD:
                begin
                    state_reg <= ST_SQ_CMP;
                end
                ST_SQ_CMP:
                begin
                    state_reg <= (k_reg == 4'd0) ? ST_RD_FIN : ST_SQ_ADD;
                end
                ST_RD_FIN:
                begin
                    if (cov_neg_reg)
                    begin
                        res_corr_reg <= neg_lo16;
                    end
                    else
                    begin
                        res_corr_reg <= (lo16 > 16'd32767) ? 16'd32767 : lo16;
                    end
                    res_status_reg <= STATUS_OK;
                    state_reg      <= ST_OUT;
                end
                // hand the result to the output register once it is free
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_corr_reg   <= res_corr_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        mul_p_reg   <= {32'd0, mul_a} * {32'd0, mul_b};
        mul_neg_reg <= mul_neg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_reg    <= s_axis_tdata[11:0];
                    sample_reg <= s_axis_tdata[27:12];
                    hyp_reg    <= s_axis_tdata[43:28];
                end
            end
            ST_HYP_DEV:
            begin
                dev_reg     <= hyp_e;
                div_rem_reg <= '0;
                div_quo_reg <= mag33(hyp_e);
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                // restoring step, one quotient bit a cycle
                div_rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, count_reg}) : rem_sh[31:0];
                div_quo_reg <= {div_quo_reg[30:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            ST_PT_LOAD:
            begin
                pmean_reg <= rd_entry.mean;
                pm2_reg   <= rd_entry.m2;
                pcov_reg  <= rd_entry.cov;
            end
            ST_PT_DEV:
            begin
                dev_reg     <= pt_e;
                div_rem_reg <= '0;
                div_quo_reg <= mag33(pt_e);
                div_cnt_reg <= '0;
            end
            ST_PT_MEAN:
            begin
                pmean_reg <= mean_step(pmean_reg, div_q);
            end
            ST_PT_MUL2:
            begin
                pm2_reg <= sat_add(pm2_reg, sprod);
            end
            ST_RD_LOAD:
            begin
                // first product: m2x * m2y
                wa_reg      <= rd_entry.m2;
                wb_reg      <= hm2_reg;
                acc_reg     <= '0;
                wcnt_reg    <= '0;
                wsel_reg    <= 1'b0;
                cov_neg_reg <= rd_entry.cov[63];
                cov_mag_reg <= rd_entry.cov[63] ? (64'd0 - rd_entry.cov) : rd_entry.cov;
            end
            ST_WACC:
            begin
                if (wcnt_reg == 2'd3)
                begin
                    if (!wsel_reg)
                    begin
                        // second product: cov squared
                        den_reg  <= acc_sum;
                        wa_reg   <= cov_mag_reg;
                        wb_reg   <= cov_mag_reg;
                        acc_reg  <= '0;
                        wcnt_reg <= '0;
                        wsel_reg <= 1'b1;
                    end
                    else
                    begin
                        num_reg  <= {32'd0, acc_sum} << 30;
                        sq_s_reg <= '0;
                        sq_a_reg <= '0;
                        sq_b_reg <= {32'd0, den_reg} << 30;
                        k_reg    <= 4'd15;
                        q_reg    <= '0;
                    end
                end
                else
                begin
                    acc_reg  <= acc_sum;
                    wcnt_reg <= wcnt_reg + 2'd1;
                end
            end
            ST_SQ_ADD:
            begin
                // (q + 2^k)^2 * den = s + (q*den << k+1) + (den << 2k)
                cand_reg <= sq_s_reg + sq_a_reg + sq_b_reg;
            end
            ST_SQ_CMP:
            begin
                if (cand_reg <= num_reg)
                begin
                    sq_s_reg <= cand_reg;
                    sq_a_reg <= (sq_a_reg + (sq_b_reg << 1)) >> 1;
                    q_reg    <= q_reg | (16'd1 << k_reg);
                end
                else
                begin
                    sq_a_reg <= sq_a_reg >> 1;
                end
                sq_b_reg <= sq_b_reg >> 2;
                k_reg    <= k_reg - 4'd1;
            end
            default:
            begin
                dev_reg <= dev_reg;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_corr_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire

FILE: hdl/ocpa_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module ocpa_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
